FILE: rtl/core/spq_pkg.sv
`default_nettype none
package spq_pkg;

   localparam logic [1:0] CMD_PUSH = 2'd0;
   localparam logic [1:0] CMD_POP  = 2'd1;
   localparam logic [1:0] CMD_PEEK = 2'd2;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
   localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

   localparam int VALUE_W = 32;
   localparam int COUNT_OUT_W = 5;

   typedef logic [VALUE_W-1:0] value_type;

endpackage
`default_nettype wire

FILE: rtl/core/spq_store.sv
`default_nettype none
module spq_store
   import spq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW = 4
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire value_type     wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output value_type          rd_data
);

   value_type mem [DEPTH];
   value_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/sorted_priority_queue.sv
`default_nettype none
// Bounded max-priority queue holding up to CAPACITY signed 32-bit values in
// descending order in a single-port-write, registered-read memory used as a
// circular buffer. Peek, pop on empty and push on full need no memory access; a
// pop does one memory read to fetch the new head; a push scans from the tail
// toward the head, moving each smaller entry down by one slot, then writes the
// pushed value into the freed slot. A stalled result waits until the output
// register is free. Equal values leave in arrival order. The block takes one
// word at a time: req_stall stays high from acceptance until the result is
// loaded into the output register.
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic signed [31:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [31:0] rsp_top_value,
   output logic             rsp_not_empty,
   output logic [4:0]       rsp_entry_count,
   output logic [1:0]       rsp_status
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PCHK  = 3'd1;
   localparam logic [2:0] S_PRD   = 3'd2;
   localparam logic [2:0] S_PCMP  = 3'd3;
   localparam logic [2:0] S_POPRD = 3'd4;
   localparam logic [2:0] S_POPW  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;
   value_type     value_ff, value_in;
   value_type     top_ff, top_in;
   logic [1:0]    status_ff, status_in;

   logic          rsp_valid_ff, rsp_valid_in;
   value_type     rsp_top_ff, rsp_top_in;
   logic          rsp_ne_ff, rsp_ne_in;
   logic [4:0]    rsp_cnt_ff, rsp_cnt_in;
   logic [1:0]    rsp_st_ff, rsp_st_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   value_type     wr_data;
   logic [AW-1:0] rd_addr;
   value_type     rd_data;
   logic          accept;
   logic          rsp_free;
   logic [31:0]   count_ext;

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] l);
      logic [AW:0] s;
      s = {1'b0, h} + {1'b0, l};
      if (s >= (AW+1)'(CAPACITY)) begin
         s = s - (AW+1)'(CAPACITY);
      end
      return s[AW-1:0];
   endfunction

   spq_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign count_ext = 32'(count_ff);
   assign rd_addr   = (state_ff == S_PRD) ? phys(head_ff, idx_ff - AW'(1)) : head_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      value_in     = value_ff;
      top_in       = top_ff;
      status_in    = status_ff;
      wr_en        = 1'b0;
      wr_addr      = phys(head_ff, idx_ff);
      wr_data      = value_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_top_in   = rsp_top_ff;
      rsp_ne_in    = rsp_ne_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_st_in    = rsp_st_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               value_in  = req_value;
               status_in = ST_OK;
               state_in  = S_DONE;
               if (req_command == CMD_PUSH) begin
                  if (count_ff >= CW'(CAPACITY)) begin
                     status_in = ST_PUSH_FULL;
                  end else begin
                     idx_in   = count_ff[AW-1:0];
                     state_in = S_PCHK;
                  end
               end else if (req_command == CMD_POP) begin
                  if (count_ff == '0) begin
                     status_in = ST_POP_EMPTY;
                  end else begin
                     head_in  = phys(head_ff, AW'(1));
                     count_in = count_ff - CW'(1);
                     state_in = S_POPRD;
                  end
               end
            end
         end
         S_PCHK: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               top_in   = value_ff;
               count_in = count_ff + CW'(1);
               state_in = S_DONE;
            end else begin
               state_in = S_PRD;
            end
         end
         S_PRD: begin
            state_in = S_PCMP;
         end
         S_PCMP: begin
            wr_en = 1'b1;
            if ($signed(rd_data) >= $signed(value_ff)) begin
               count_in = count_ff + CW'(1);
               state_in = S_DONE;
            end else begin
               wr_data  = rd_data;
               idx_in   = idx_ff - AW'(1);
               state_in = S_PCHK;
            end
         end
         S_POPRD: begin
            state_in = (count_ff == '0) ? S_DONE : S_POPW;
         end
         S_POPW: begin
            top_in   = rd_data;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_top_in   = (count_ff == '0) ? '0 : top_ff;
               rsp_ne_in    = (count_ff != '0);
               rsp_cnt_in   = count_ext[COUNT_OUT_W-1:0];
               rsp_st_in    = status_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      value_ff   <= value_in;
      top_ff     <= top_in;
      status_ff  <= status_in;
      rsp_top_ff <= rsp_top_in;
      rsp_ne_ff  <= rsp_ne_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_top_value   = $signed(rsp_top_ff);
   assign rsp_not_empty   = rsp_ne_ff;
   assign rsp_entry_count = rsp_cnt_ff;
   assign rsp_status      = rsp_st_ff;

endmodule
`default_nettype wire

FILE: tb/sv/sorted_priority_queue_tb.sv
module sorted_priority_queue_tb;
   import spq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;

   typedef struct {
      logic signed [31:0] top_value;
      logic               not_empty;
      logic [4:0]         entry_count;
      logic [1:0]         status;
   } queue_view_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [1:0] req_command;
   logic signed [31:0] req_value;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [31:0] rsp_top_value;
   logic rsp_not_empty;
   logic [4:0] rsp_entry_count;
   logic [1:0] rsp_status;

   logic signed [31:0] model_entries[$];
   queue_view_type awaited_views[$];
   queue_view_type oldest_view;
   int mismatch_count = 0;
   int cycle_count = 0;
   int gap_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;

   sorted_priority_queue #(.CAPACITY(CAPACITY)) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_top_value(rsp_top_value),
      .rsp_not_empty(rsp_not_empty),
      .rsp_entry_count(rsp_entry_count),
      .rsp_status(rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic queue_view_type next_queue_view(input logic [1:0] command,
                                                      input logic signed [31:0] value);
      queue_view_type view;
      int pos;
      view.status = ST_OK;
      pos = 0;
      if (command == CMD_PUSH) begin
         if (model_entries.size() >= CAPACITY) begin
            view.status = ST_PUSH_FULL;
         end else begin
            while (pos < model_entries.size() && model_entries[pos] >= value)
               pos++;
            model_entries.insert(pos, value);
         end
      end else if (command == CMD_POP) begin
         if (model_entries.size() == 0)
            view.status = ST_POP_EMPTY;
         else
            void'(model_entries.pop_front());
      end
      view.not_empty = (model_entries.size() != 0);
      view.top_value = view.not_empty ? model_entries[0] : 32'sd0;
      view.entry_count = 5'(model_entries.size());
      return view;
   endfunction

   task automatic issue_command(input logic [1:0] command, input logic signed [31:0] value);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < gap_pct)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= command;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      awaited_views.push_back(next_queue_view(command, value));
   endtask

   task automatic test_empty_queue();
      issue_command(CMD_PEEK, 32'sd0);
      issue_command(CMD_POP, VALUE_MAX);
      issue_command(CMD_UNUSED, VALUE_MIN);
   endtask

   task automatic test_value_extremes();
      issue_command(CMD_PUSH, VALUE_MIN);
      issue_command(CMD_PUSH, VALUE_MAX);
      issue_command(CMD_PUSH, 32'sd0);
      issue_command(CMD_PUSH, -32'sd1);
      issue_command(CMD_PUSH, -32'sd1);
      issue_command(CMD_PEEK, 32'sd7);
      issue_command(CMD_UNUSED, 32'sd5);
   endtask

   task automatic test_full_queue();
      for (int i = 0; i < CAPACITY - 5; i++)
         issue_command(CMD_PUSH, 32'sd1000 * i - 32'sd5000);
      issue_command(CMD_PUSH, VALUE_MAX);
      issue_command(CMD_POP, 32'sd0);
   endtask

   task automatic test_random_traffic(input int item_total);
      int push_weight;
      int pick;
      logic [1:0] command;
      logic signed [31:0] value;
      for (int n = 0; n < item_total; n++) begin
         case (n)
            0:   begin gap_pct = 0;  stall_pct = 0;  end
            60:  begin gap_pct = 20; stall_pct = 20; end
            180: begin gap_pct = 60; stall_pct = 10; end
            260: begin gap_pct = 10; stall_pct = 60; end
            340: begin gap_pct = 0;  stall_pct = 0;  end
            default: ;
         endcase
         push_weight = ((n / 40) % 2 == 0) ? 75 : 25;
         pick = $urandom_range(0, 99);
         if (pick < push_weight)
            command = CMD_PUSH;
         else if (pick < 92)
            command = CMD_POP;
         else if (pick < 97)
            command = CMD_PEEK;
         else
            command = CMD_UNUSED;
         case ($urandom_range(0, 9))
            0:       value = VALUE_MAX;
            1:       value = VALUE_MIN;
            2, 3, 4: value = $signed($urandom_range(0, 8)) - 32'sd4;
            default: value = $urandom;
         endcase
         issue_command(command, value);
      end
   endtask

   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (!reset && $urandom_range(0, 99) < stall_pct)
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                      : $urandom_range(1, 3);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_views.size() == 0) begin
            $error("unexpected word: top_value %0d, entry_count %0d",
                   rsp_top_value, rsp_entry_count);
            mismatch_count++;
         end else begin
            oldest_view = awaited_views.pop_front();
            if (rsp_top_value !== oldest_view.top_value) begin
               $error("top_value: expected %0d, got %0d", oldest_view.top_value,
                      rsp_top_value);
               mismatch_count++;
            end
            if (rsp_not_empty !== oldest_view.not_empty) begin
               $error("not_empty: expected %0d, got %0d", oldest_view.not_empty,
                      rsp_not_empty);
               mismatch_count++;
            end
            if (rsp_entry_count !== oldest_view.entry_count) begin
               $error("entry_count: expected %0d, got %0d", oldest_view.entry_count,
                      rsp_entry_count);
               mismatch_count++;
            end
            if (rsp_status !== oldest_view.status) begin
               $error("status: expected %0d, got %0d", oldest_view.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_PEEK;
      req_value = 32'sd0;
      rsp_stall = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      gap_pct = 30;
      stall_pct = 30;
      test_empty_queue();
      test_value_extremes();
      test_full_queue();
      test_random_traffic(400);

      // drop valid once the last word is taken
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_views.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_views.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
